// ===== hw/rtl/ppfc_pkg.sv =====
package ppfc_pkg;

	localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
	localparam logic [7:0]  ESCAPE_BYTE  = 8'h7D;
	localparam logic [7:0]  ESCAPE_XOR   = 8'h20;
	localparam logic [15:0] FCS_POLY     = 16'h8408;
	localparam logic [15:0] FCS_GOOD_VAL = 16'hF0B8;
	localparam logic [15:0] FCS_PRESET   = 16'hFFFF;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_FLAG,
		KIND_ESC,
		KIND_DATA
	} kind_t;

	// one classified request between the front and the back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] data);
		logic [15:0] v;
		v = {8'h00, fcs[7:0] ^ data};
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ FCS_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return {8'h00, fcs[15:8]} ^ v;
	endfunction

endpackage

// ===== hw/rtl/ppfc_front.sv =====
module ppfc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	output ppfc_pkg::item_t item
);
	import ppfc_pkg::*;

	logic escape_q;

	always_comb begin
		item.data = rx_byte;
		if (rx_byte == FLAG_BYTE) begin
			item.kind = KIND_FLAG;
		end else if (rx_byte == ESCAPE_BYTE) begin
			item.kind = KIND_ESC;
		end else begin
			item.kind = KIND_DATA;
			if (escape_q) begin
				item.data = rx_byte ^ ESCAPE_XOR;
			end
		end
	end

	// a flag drops a pending escape; a second escape keeps it pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
		end else if (accept) begin
			case (item.kind)
				KIND_FLAG: escape_q <= 1'b0;
				KIND_ESC:  escape_q <= 1'b1;
				KIND_DATA: escape_q <= 1'b0;
				default:   escape_q <= 1'b0;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ppfc_queue.sv =====
module ppfc_queue #(
	parameter int Depth = ppfc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ppfc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output ppfc_pkg::item_t pop_item,
	output logic            empty
);
	import ppfc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t           mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ppfc_back.sv =====
module ppfc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  ppfc_pkg::item_t head,
	output logic            q_pop,
	output logic            res_valid,
	output logic [15:0]     res_length,
	output logic            res_good,
	input  logic            res_pop
);
	import ppfc_pkg::*;

	logic [15:0] count_q;
	logic [15:0] fcs_q;
	logic        valid_q;
	logic [15:0] length_q;
	logic        good_q;
	logic        emit;

	// a closing flag waits only while the result register stays occupied
	assign q_pop = !q_empty && (head.kind != KIND_FLAG || count_q == '0 || !valid_q || res_pop);
	assign emit  = q_pop && head.kind == KIND_FLAG && count_q != '0;

	assign res_valid  = valid_q;
	assign res_length = length_q;
	assign res_good   = good_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fcs_q   <= FCS_PRESET;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				case (head.kind)
					KIND_FLAG: begin
						count_q <= '0;
						fcs_q   <= FCS_PRESET;
					end
					KIND_ESC: begin
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
					end
					KIND_DATA: begin
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
						fcs_q <= fcs_update(fcs_q, head.data);
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (res_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			length_q <= count_q;
			good_q   <= (fcs_q == FCS_GOOD_VAL);
		end
	end

endmodule

// ===== hw/rtl/ppp_async_frame_checker.sv =====
// Receive-side frame checker for an asynchronous PPP link.
// Input channel: raw link bytes on rx_byte, taken when push is high and full low.
// Result channel: one request per closed, non-empty frame with frame_length
// (raw bytes between flags, escapes counted, saturating at 65535) and fcs_good
// (FCS-16 residue equals the good value). The oldest result is shown while
// empty is low and leaves when pop is high.
// Throughput: one byte per cycle while full is low. A front stage classifies each
// byte and removes escaping, a short queue (QueueDepth entries) holds the
// classified bytes, and a back stage updates the count and, for data bytes, the
// byte-wide CRC as it pops each byte.
// A closing flag is registered in the queue and then in the result register;
// its result trails bytes still queued ahead of it.
// A held result stalls only closing flags in the back stage; other bytes keep
// flowing until the queue fills, and full then backs up the input.
// Reset clears the escape state, the count, the queue and the result register
// and presets the FCS to all ones.
module ppp_async_frame_checker #(
	parameter int QueueDepth = ppfc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] frame_length,
	output logic        fcs_good
);
	import ppfc_pkg::*;

	item_t front_item;
	item_t head_item;
	logic  accept;
	logic  q_pop;
	logic  q_empty;
	logic  res_valid;

	assign accept = push && !full;
	assign empty  = !res_valid;

	ppfc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.item    (front_item)
	);

	ppfc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (full),
		.pop       (q_pop),
		.pop_item  (head_item),
		.empty     (q_empty)
	);

	ppfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head_item),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_length (frame_length),
		.res_good   (fcs_good),
		.res_pop    (pop && res_valid)
	);

endmodule

// ===== hw/rtl/ppfc_checker.sv =====
module ppfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [15:0] frame_length,
	input logic        fcs_good
);

	// a waiting result holds until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(frame_length) && $stable(fcs_good))
	else $error("result changed while stalled");

	// only non-empty frames produce a result
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> frame_length != 16'h0000)
	else $error("zero-length frame reported");

	// the queue can only fill on a push
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
	else $error("full rose without a push");

	// the input does not back up while empty is high now and was high at the earlier samples checked
	assert property (@(posedge clk) disable iff (!arst_n)
		empty && $past(empty) && $past(empty, 2) |-> !full)
	else $error("full without a held result");

endmodule

bind ppp_async_frame_checker ppfc_checker u_ppfc_checker (.*);
